// ----- design/sle_pkg.sv -----
// Package for the sequential list engine: command codes, status codes, sizes.
`default_nettype none
package sle_pkg;
   localparam int CAPACITY_DEFAULT = 64;
   localparam int DATA_W = 32;
   localparam int POS_W = 7;

   typedef enum logic [2:0] {
      CMD_INSERT    = 3'd0,
      CMD_DELETE    = 3'd1,
      CMD_LOCATE    = 3'd2,
      CMD_DEL_MIN   = 3'd3,
      CMD_DEL_EQ    = 3'd4,
      CMD_DEL_OPEN  = 3'd5,
      CMD_DEL_CLOSE = 3'd6,
      CMD_NOP       = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_POS   = 3'd1,
      ST_FULL      = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_BAD_RANGE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_WALK,
      FSM_DONE
   } fsm_type;

   // Per-cycle control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic pop;    // the word in cell 0 leaves; every cell takes its right neighbor
      logic push;   // the tail word enters at the end of the held list
   } ctl_type;
endpackage
`default_nettype wire

// ----- design/sequential_list_engine_core.sv -----
// Top level of the sequential list engine: sequencer and chain of cells.
//
// Usage: drive req_cmd, req_position, req_value and req_upper_bound and
// raise start while busy is low; the command is transferred at that edge.
// busy stays high until the result has been shown. Exactly one result
// comes back per command, shown for one cycle with rsp_valid; the
// receiver cannot stall it. The list lives in a chain of CAPACITY cells
// used as a queue: each walk step pops the word in cell 0 and either
// pushes it back at the end, drops it, or pushes another word; the insert
// step pushes the new word with no pop. After one pass over the list the
// survivors sit in order at cells 0..length-1. A command takes S walk
// steps, then shows its result in the next cycle, and the next command
// can be transferred once busy is low again. S is length+1 for insert,
// length for delete, locate, delete-equal and the range deletes, twice
// the length for delete-min (search lap, then removal lap), and 0 for a
// rejected command, the unused code or any other command on an empty list.
// Reset clears the length and the sequencer; the cell words are not
// cleared and are never read beyond the length.
`default_nettype none
module sequential_list_engine_core #(
   parameter int CAPACITY = sle_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [2:0]                        req_cmd,
   input  wire logic [sle_pkg::POS_W-1:0]         req_position,
   input  wire logic signed [sle_pkg::DATA_W-1:0] req_value,
   input  wire logic signed [sle_pkg::DATA_W-1:0] req_upper_bound,
   output logic                                   rsp_valid,
   output logic [2:0]                             rsp_status,
   output logic signed [sle_pkg::DATA_W-1:0]      rsp_result_value,
   output logic [sle_pkg::POS_W-1:0]              rsp_found_position,
   output logic [sle_pkg::POS_W-1:0]              rsp_removed_count,
   output logic [sle_pkg::POS_W-1:0]              rsp_list_length
);
   import sle_pkg::*;
   localparam int CW = $clog2(CAPACITY + 1);   // counts up to CAPACITY
   localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

   fsm_type state_ff, state_in;
   cmd_type cmd_ff;
   status_type status_ff, st_new;
   logic walk_new;
   logic signed [DATA_W-1:0] val_ff, up_ff, res_ff, min_ff, last_ff;
   logic [CW-1:0] count_ff, len_ff, idx_ff, pm1_ff, minidx_ff, removed_ff, cm1;
   logic [POS_W-1:0] found_ff;
   logic got_ff, ins_ff, phase_ff;
   logic walking, ins_step, at_last, at_pos, at_min, match, pop, push, final_step;
   logic [DATA_W-1:0] head, tail_word;
   logic signed [DATA_W-1:0] hs;
   ctl_type ctl;
   logic [CAPACITY-1:0][DATA_W-1:0] ring;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [DATA_W-1:0] nb;
         if (g == CAPACITY - 1) begin : g_t
            assign nb = tail_word;
         end else begin : g_n
            assign nb = ring[g+1];
         end
         sle_cell #(.CAPACITY(CAPACITY), .IDX(g)) u_cell (
            .clock(clock), .ctl(ctl), .len(len_ff), .word_next(nb),
            .word_tail(tail_word), .word_out(ring[g]));
      end
   endgenerate
   assign head = ring[0];
   assign hs = signed'(head);

   // Check the command against the length at the transfer edge.
   always_comb begin
      st_new = ST_OK;
      case (cmd_type'(req_cmd))
         CMD_INSERT:
            if (req_position == '0 || XW'(req_position) > XW'(count_ff) + XW'(1))
               st_new = ST_BAD_POS;
            else if (count_ff >= CW'(CAPACITY)) st_new = ST_FULL;
         CMD_DELETE:
            if (req_position == '0 || XW'(req_position) > XW'(count_ff))
               st_new = ST_BAD_POS;
         CMD_DEL_MIN: if (count_ff == '0) st_new = ST_EMPTY;
         CMD_DEL_OPEN, CMD_DEL_CLOSE:
            if (req_value >= req_upper_bound) st_new = ST_BAD_RANGE;
         default: ;
      endcase
      walk_new = (st_new == ST_OK) && ((cmd_type'(req_cmd) == CMD_INSERT)
                 || (cmd_type'(req_cmd) != CMD_NOP && count_ff != '0));
   end

   // One walk step: idx_ff is the index of the word now in cell 0.
   always_comb begin
      walking = (state_ff == FSM_WALK);
      cm1 = count_ff - CW'(1);
      at_last = (idx_ff == cm1);
      at_pos = (idx_ff == pm1_ff);
      at_min = (idx_ff == minidx_ff);
      ins_step = 1'b0;
      match = 1'b0;
      pop = 1'b1;
      push = 1'b1;
      tail_word = head;
      final_step = at_last;
      case (cmd_ff)
         CMD_INSERT: begin
            ins_step = !ins_ff && at_pos;
            pop = !ins_step;
            if (ins_step) tail_word = val_ff;
            final_step = ins_step ? (idx_ff == count_ff) : (at_last && ins_ff);
         end
         CMD_DELETE: begin
            match = at_pos;
            push = !match;
         end
         CMD_DEL_EQ: begin
            match = (hs == val_ff);
            push = !match;
         end
         CMD_DEL_OPEN: begin
            match = (hs > val_ff) && (hs < up_ff);
            push = !match;
         end
         CMD_DEL_CLOSE: begin
            match = (hs >= val_ff) && (hs <= up_ff);
            push = !match;
         end
         CMD_DEL_MIN: begin
            final_step = at_last && phase_ff;
            // second lap: the minimum's slot takes the last word, drop the last
            if (phase_ff) begin
               if (at_min) begin
                  match = 1'b1;
                  push = !at_last;
                  tail_word = last_ff;
               end else if (at_last) begin
                  push = 1'b0;
               end
            end
         end
         default: ;
      endcase
      ctl.pop = walking && pop;
      ctl.push = walking && push;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: if (start) state_in = walk_new ? FSM_WALK : FSM_DONE;
         FSM_WALK: if (final_step) state_in = FSM_DONE;
         FSM_DONE: state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != FSM_IDLE);
      rsp_valid = (state_ff == FSM_DONE);
      rsp_status = status_ff;
      rsp_result_value = res_ff;
      rsp_found_position = found_ff;
      rsp_removed_count = POS_W'(removed_ff);
      rsp_list_length = POS_W'(len_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == FSM_DONE) count_ff <= len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == FSM_IDLE && start) begin
         cmd_ff <= cmd_type'(req_cmd);
         pm1_ff <= CW'(XW'(req_position) - XW'(1));
         val_ff <= req_value;
         up_ff <= req_upper_bound;
         status_ff <= st_new;
         len_ff <= count_ff;
         idx_ff <= '0;
         removed_ff <= '0;
         res_ff <= '0;
         found_ff <= '0;
         got_ff <= 1'b0;
         ins_ff <= 1'b0;
         phase_ff <= 1'b0;
         minidx_ff <= '0;
      end else if (walking) begin
         if (ins_step) ins_ff <= 1'b1;
         else if (cmd_ff == CMD_DEL_MIN && !phase_ff && at_last) begin
            idx_ff <= '0;
            phase_ff <= 1'b1;
         end else idx_ff <= idx_ff + CW'(1);
         if (pop && !push) len_ff <= len_ff - CW'(1);
         else if (!pop && push) len_ff <= len_ff + CW'(1);
         if (match) begin
            removed_ff <= removed_ff + CW'(1);
            if (cmd_ff == CMD_DELETE || cmd_ff == CMD_DEL_MIN) res_ff <= hs;
         end
         if (cmd_ff == CMD_LOCATE && !got_ff && hs == val_ff) begin
            got_ff <= 1'b1;
            found_ff <= POS_W'(idx_ff + CW'(1));
         end
         // first lap: track the first minimum and hold the last word
         if (cmd_ff == CMD_DEL_MIN && !phase_ff) begin
            if (idx_ff == '0 || hs < min_ff) begin
               min_ff <= hs;
               minidx_ff <= idx_ff;
            end
            if (at_last) last_ff <= hs;
         end
      end
   end
endmodule
`default_nettype wire

// ----- design/sle_cell.sv -----
// One cell of the list queue: holds a word, takes its neighbor on a pop or the tail word.
`default_nettype none
module sle_cell #(
   parameter int CAPACITY = sle_pkg::CAPACITY_DEFAULT,
   parameter int IDX = 0
) (
   input  wire logic                                clock,
   input  wire sle_pkg::ctl_type                    ctl,
   input  wire logic [$clog2(CAPACITY + 1)-1:0]     len,
   input  wire logic [sle_pkg::DATA_W-1:0]          word_next,
   input  wire logic [sle_pkg::DATA_W-1:0]          word_tail,
   output logic      [sle_pkg::DATA_W-1:0]          word_out
);
   import sle_pkg::*;
   localparam int CW = $clog2(CAPACITY + 1);

   logic [DATA_W-1:0] word_ff;
   logic take_tail;

   // The end slot is len-1 after a pop and len without one.
   always_comb begin
      if (ctl.pop) take_tail = ctl.push && (CW'(IDX) == len - CW'(1));
      else take_tail = ctl.push && (CW'(IDX) == len);
   end

   always_ff @(posedge clock) begin
      if (take_tail) word_ff <= word_tail;
      else if (ctl.pop) word_ff <= word_next;
   end
   assign word_out = word_ff;
endmodule
`default_nettype wire

// ----- bench/sequential_list_engine_core_tb.sv -----
// Testbench for the sequential list engine: directed and random commands, checked result by result.
`default_nettype none
module sequential_list_engine_core_tb;
   import sle_pkg::*;

   localparam int CAP = 64;
   localparam int LIMIT = 20000;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] result_value;
      logic [6:0]  found_position;
      logic [6:0]  removed_count;
      logic [6:0]  list_length;
   } outcome_type;

   class list_scoreboard;
      logic signed [31:0] words[$];
      outcome_type pending[$];
      int errors;

      function void note_command(logic [2:0] cmd, logic [6:0] pos,
                                 logic signed [31:0] val, logic signed [31:0] upper);
         outcome_type o;
         int m, n;
         logic signed [31:0] x;
         logic signed [31:0] kept[$];
         o = '{ST_OK, 32'd0, 7'd0, 7'd0, 7'd0};
         n = words.size();
         case (cmd)
            CMD_INSERT: begin
               if (pos < 1 || pos > n + 1) o.status = ST_BAD_POS;
               else if (n >= CAP) o.status = ST_FULL;
               else words.insert(pos - 1, val);
            end
            CMD_DELETE: begin
               if (pos < 1 || pos > n) o.status = ST_BAD_POS;
               else begin
                  o.result_value = words[pos - 1];
                  words.delete(pos - 1);
                  o.removed_count = 7'd1;
               end
            end
            CMD_LOCATE: begin
               for (int j = n - 1; j >= 0; j--)
                  if (words[j] == val) o.found_position = 7'(j + 1);
            end
            CMD_DEL_MIN: begin
               if (n == 0) o.status = ST_EMPTY;
               else begin
                  m = 0;
                  for (int j = 1; j < n; j++) if (words[j] < words[m]) m = j;
                  o.result_value = words[m];
                  words[m] = words[n - 1];
                  words.delete(n - 1);
                  o.removed_count = 7'd1;
               end
            end
            CMD_DEL_EQ, CMD_DEL_OPEN, CMD_DEL_CLOSE: begin
               if (cmd != CMD_DEL_EQ && val >= upper) o.status = ST_BAD_RANGE;
               else begin
                  foreach (words[j]) begin
                     x = words[j];
                     if (!(cmd == CMD_DEL_EQ ? x == val :
                           cmd == CMD_DEL_OPEN ? (val < x && x < upper) :
                           (val <= x && x <= upper)))
                        kept.push_back(x);
                  end
                  o.removed_count = 7'(n - kept.size());
                  words = kept;
               end
            end
            default: ;
         endcase
         o.list_length = 7'(words.size());
         pending.push_back(o);
      endfunction

      function void check_result(outcome_type got);
         outcome_type e;
         if (pending.size() == 0) begin
            $error("result with nothing expected");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, got.status); errors++;
         end
         if (got.result_value !== e.result_value) begin
            $error("result_value exp %h got %h", e.result_value, got.result_value); errors++;
         end
         if (got.found_position !== e.found_position) begin
            $error("found_position exp %0d got %0d", e.found_position, got.found_position);
            errors++;
         end
         if (got.removed_count !== e.removed_count) begin
            $error("removed_count exp %0d got %0d", e.removed_count, got.removed_count);
            errors++;
         end
         if (got.list_length !== e.list_length) begin
            $error("list_length exp %0d got %0d", e.list_length, got.list_length); errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1, start = 0;
   logic [2:0] req_cmd = 0;
   logic [6:0] req_position = 0;
   logic signed [31:0] req_value = 0, req_upper_bound = 0;
   wire busy, rsp_valid;
   wire [2:0] rsp_status;
   wire signed [31:0] rsp_result_value;
   wire [6:0] rsp_found_position, rsp_removed_count, rsp_list_length;

   sequential_list_engine_core dut (.*);

   list_scoreboard board = new();
   int quiet_cycles = 0;
   bit allow_gaps = 1;

   initial forever #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_result('{rsp_status, rsp_result_value, rsp_found_position,
                              rsp_removed_count, rsp_list_length});
      if (!reset && ((start && !busy) || rsp_valid)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Drive one command and hold it until the transfer edge.
   task automatic send(logic [2:0] cmd, logic [6:0] pos, logic [31:0] val, logic [31:0] upper);
      @(posedge clock);
      if (allow_gaps && $urandom_range(3) == 0)
         repeat ($urandom_range(17, 1)) @(posedge clock);
      start <= 1;
      req_cmd <= cmd;
      req_position <= pos;
      req_value <= val;
      req_upper_bound <= upper;
      do @(posedge clock); while (busy);
      board.note_command(cmd, pos, val, upper);
      start <= 0;
   endtask

   function automatic logic [31:0] pick_word();
      int n;
      n = board.words.size();
      case ($urandom_range(4))
         0: return $urandom;
         1: return n ? board.words[$urandom_range(n - 1)] : 32'h8000_0000;
         2: return {$urandom_range(1) ? 28'hfff_ffff : 28'h0, 4'($urandom)};
         3: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return $signed(4'($urandom));
      endcase
   endfunction

   task automatic random_command();
      int n, r;
      logic [2:0] cmd;
      logic [6:0] pos;
      logic signed [31:0] a, b;
      n = board.words.size();
      r = $urandom_range(99);
      // Favor inserts while short so the list fills and drains over the run.
      cmd = r < (n < 40 ? 45 : 25) ? CMD_INSERT : 3'($urandom_range(7));
      if ($urandom_range(9) == 0) pos = 7'($urandom);
      else if (cmd == CMD_INSERT) pos = 7'($urandom_range(n + 1, 1));
      else pos = n ? 7'($urandom_range(n, 1)) : 7'd1;
      a = pick_word();
      b = pick_word();
      if ((cmd == CMD_DEL_OPEN || cmd == CMD_DEL_CLOSE) && $urandom_range(7) != 0 && a > b)
         {a, b} = {b, a};
      send(cmd, pos, a, b);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      allow_gaps = 0;
      send(CMD_DEL_MIN, 0, 0, 0);
      send(CMD_DELETE, 1, 0, 0);
      send(CMD_INSERT, 0, 5, 0);
      send(CMD_INSERT, 2, 5, 0);
      send(CMD_INSERT, 1, 32'h8000_0000, 0);
      send(CMD_INSERT, 2, 32'h7fff_ffff, 0);
      send(CMD_INSERT, 1, 32'h7fff_ffff, 0);
      send(CMD_INSERT, 4, -1, 0);
      send(CMD_INSERT, 2, 32'h8000_0000, 0);
      send(CMD_LOCATE, 0, 32'h7fff_ffff, 0);
      send(CMD_LOCATE, 0, 123, 0);
      send(CMD_DEL_MIN, 0, 0, 0);
      send(CMD_DELETE, 127, 0, 0);
      send(CMD_DELETE, 5, 0, 0);
      send(CMD_DEL_OPEN, 0, 3, 3);
      send(CMD_DEL_CLOSE, 0, 9, -9);
      send(CMD_DEL_OPEN, 0, 32'h8000_0000, 32'h7fff_ffff);
      send(CMD_DEL_CLOSE, 0, 32'h8000_0000, 32'h7fff_ffff);
      send(CMD_NOP, 127, -1, -1);
      for (int k = 0; k < 66; k++) send(CMD_INSERT, 1, 32'(k % 3), 0);
      send(CMD_INSERT, 1, 7, 0);
      send(CMD_DEL_EQ, 0, 1, 0);
      allow_gaps = 1;
      for (int k = 0; k < 1750; k++) begin
         if (k == 1650) allow_gaps = 0;
         if (k == 800) wait (board.pending.size() == 0);
         random_command();
      end
      wait (board.pending.size() == 0);
      repeat (CAP + 8) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire
